>>> sv/dimfm_pkg.sv
// Shared types, register indexes and constants for the inverter fault monitor.
package dimfm_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_CURRENT_LIMIT  = 2'd0;
    localparam logic [1:0] REG_VOLTAGE_HIGH   = 2'd1;
    localparam logic [1:0] REG_VOLTAGE_LOW    = 2'd2;
    localparam logic [1:0] REG_DEBOUNCE_COUNT = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Fault flag bit positions
    localparam int FLAG_OVERCURRENT  = 0;
    localparam int FLAG_OVERVOLTAGE  = 1;
    localparam int FLAG_UNDERVOLTAGE = 2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Register reset values
    localparam logic [14:0] CURRENT_LIMIT_RST  = 15'h7FFF;
    localparam logic [15:0] VOLTAGE_HIGH_RST   = 16'hFFFF;
    localparam logic [15:0] VOLTAGE_LOW_RST    = 16'h0000;
    localparam logic [15:0] DEBOUNCE_COUNT_RST = 16'h0001;

    typedef struct packed {
        logic signed [15:0] current_a;
        logic signed [15:0] current_b;
        logic signed [15:0] current_c;
        logic        [15:0] bus_voltage;
    } t_in_req;

    typedef struct packed {
        logic [2:0] fault_flags;
        logic       trip;
    } t_out_req;

    typedef struct packed {
        logic [14:0] current_limit;
        logic [15:0] voltage_high;
        logic [15:0] voltage_low;
        logic [15:0] debounce_count;
    } t_cfg;

endpackage

>>> sv/dimfm_cfg.sv
// Configuration register file: thresholds and debounce limit.
module dimfm_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dimfm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dimfm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output dimfm_pkg::t_cfg                   o_cfg
);
    import dimfm_pkg::*;

    t_cfg r_cfg;

    // Write the addressed register, masking to its width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_limit  <= CURRENT_LIMIT_RST;
            r_cfg.voltage_high   <= VOLTAGE_HIGH_RST;
            r_cfg.voltage_low    <= VOLTAGE_LOW_RST;
            r_cfg.debounce_count <= DEBOUNCE_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CURRENT_LIMIT:  r_cfg.current_limit  <= i_cfg_data[14:0];
                REG_VOLTAGE_HIGH:   r_cfg.voltage_high   <= i_cfg_data;
                REG_VOLTAGE_LOW:    r_cfg.voltage_low    <= i_cfg_data;
                REG_DEBOUNCE_COUNT: r_cfg.debounce_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/dimfm_detect.sv
// Per-sample fault detection: current magnitude and bus voltage compares.
module dimfm_detect (
    input  dimfm_pkg::t_in_req i_sample,
    input  dimfm_pkg::t_cfg    i_cfg,
    output logic [2:0]         o_flags
);
    import dimfm_pkg::*;

    logic [16:0] mag_a;
    logic [16:0] mag_b;
    logic [16:0] mag_c;
    logic [16:0] limit_ext;
    logic        over_current;
    logic        over_voltage;
    logic        under_voltage;

    // Take magnitudes in 17 bits so the most negative sample reads as 32768
    assign mag_a = i_sample.current_a[15] ? (17'd0 - {1'b1, i_sample.current_a})
                                          : {1'b0, i_sample.current_a};
    assign mag_b = i_sample.current_b[15] ? (17'd0 - {1'b1, i_sample.current_b})
                                          : {1'b0, i_sample.current_b};
    assign mag_c = i_sample.current_c[15] ? (17'd0 - {1'b1, i_sample.current_c})
                                          : {1'b0, i_sample.current_c};
    assign limit_ext = {2'b00, i_cfg.current_limit};

    assign over_current  = (mag_a > limit_ext) || (mag_b > limit_ext) ||
                           (mag_c > limit_ext);
    // Overvoltage wins over undervoltage
    assign over_voltage  = i_sample.bus_voltage > i_cfg.voltage_high;
    assign under_voltage = !over_voltage && (i_sample.bus_voltage < i_cfg.voltage_low);

    always_comb begin
        o_flags                    = 3'b000;
        o_flags[FLAG_OVERCURRENT]  = over_current;
        o_flags[FLAG_OVERVOLTAGE]  = over_voltage;
        o_flags[FLAG_UNDERVOLTAGE] = under_voltage;
    end

endmodule

>>> sv/debounced_inverter_fault_monitor_unit.sv
// Top level: input register, fault detection, debounce counter, result register.
// A request is registered in the input register at acceptance, and its result is then
// registered in the result register once that register is free or its result is taken.
// Throughput: one request per cycle unless the output stalls; the output and input registers
// advance together whenever the result is taken or the output register is empty.
// Synchronous active-low reset: pipeline empty, counter and status cleared, config registers reset.
module debounced_inverter_fault_monitor_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  dimfm_pkg::t_in_req                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output dimfm_pkg::t_out_req               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [dimfm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dimfm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dimfm_pkg::*;

    t_cfg     cfg;
    t_in_req  r_in_data;
    logic     r_in_valid;
    t_out_req r_out_data;
    logic     r_out_valid;
    logic [15:0] r_fault_count;
    logic [15:0] n_fault_count;
    logic [2:0]  r_latched;
    logic [2:0]  n_latched;
    logic [2:0]  flags;
    logic        fault;
    logic        trip;
    logic        advance;

    dimfm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dimfm_detect u_detect (
        .i_sample (r_in_data),
        .i_cfg    (cfg),
        .o_flags  (flags)
    );

    // Move the held request on when the result slot is free or being taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    // Debounce: saturating count up on fault, count down toward zero when clean
    assign fault = flags != 3'b000;
    always_comb begin
        n_fault_count = r_fault_count;
        if (fault) begin
            if (r_fault_count != COUNT_MAX) begin
                n_fault_count = r_fault_count + 16'd1;
            end
        end else if (r_fault_count != 16'd0) begin
            n_fault_count = r_fault_count - 16'd1;
        end
    end
    assign trip      = fault && (n_fault_count >= cfg.debounce_count);
    assign n_latched = trip ? flags : r_latched;

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Hold the input payload while stalled
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // Update state and the result register as a request leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_fault_count <= 16'd0;
            r_latched     <= 3'b000;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_fault_count <= n_fault_count;
                r_latched     <= n_latched;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_data.fault_flags <= n_latched;
            r_out_data.trip        <= trip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
